>>> src/hccr_pkg.sv
// Package for the hotkey chord capture router: key codes, action and register codes, helpers.
`default_nettype none

package hccr_pkg;

    // Widest chord the member registers can describe.
    localparam int MAX_MEMBERS_DEF = 4;
    localparam int KEY_REGS        = 4;

    localparam logic [7:0] KEY_DELETE  = 8'h2E;
    localparam logic [7:0] KEY_P       = 8'h50;
    localparam logic [7:0] KEY_F       = 8'h46;
    localparam logic [7:0] KEY_SHIFT   = 8'h10;
    localparam logic [7:0] KEY_CONTROL = 8'h11;
    localparam logic [7:0] KEY_MENU    = 8'h12;
    localparam logic [7:0] KEY_LSHIFT  = 8'hA0;
    localparam logic [7:0] KEY_RSHIFT  = 8'hA1;
    localparam logic [7:0] KEY_LCTRL   = 8'hA2;
    localparam logic [7:0] KEY_RCTRL   = 8'hA3;
    localparam logic [7:0] KEY_LMENU   = 8'hA4;
    localparam logic [7:0] KEY_RMENU   = 8'hA5;

    localparam logic [1:0] ACT_KEY        = 2'd0;
    localparam logic [1:0] ACT_FOCUS_LOST = 2'd1;
    localparam logic [1:0] ACT_TOGGLE     = 2'd2;

    localparam logic [2:0] REG_KEY_A = 3'd0;
    localparam logic [2:0] REG_KEY_B = 3'd1;
    localparam logic [2:0] REG_KEY_C = 3'd2;
    localparam logic [2:0] REG_KEY_D = 3'd3;
    localparam logic [2:0] REG_SIZE  = 3'd4;

    localparam logic [7:0] KEY_A_RST = 8'd17;
    localparam logic [7:0] KEY_B_RST = 8'd18;
    localparam logic [7:0] KEY_C_RST = 8'd0;
    localparam logic [7:0] KEY_D_RST = 8'd0;
    localparam logic [2:0] SIZE_RST  = 3'd2;

    // Fold left/right Shift, Ctrl and Alt onto their generic codes.
    function automatic logic [7:0] merge_sides(input logic [7:0] code);
        logic [7:0] res;
        case (code)
            KEY_LSHIFT, KEY_RSHIFT: res = KEY_SHIFT;
            KEY_LCTRL, KEY_RCTRL:   res = KEY_CONTROL;
            KEY_LMENU, KEY_RMENU:   res = KEY_MENU;
            default:                res = code;
        endcase
        return res;
    endfunction

endpackage

`default_nettype wire

>>> src/hotkey_chord_capture_router.sv
// Hotkey chord capture router: top level with config registers, input stage and result stage.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one keyboard event per transfer:
//   a key event, a focus-lost event or an external capture toggle, with the
//   key code, up/down flag and the host context bits (focus, prompt, tab).
//   Output channel (out_valid / out_stall) returns exactly one result per event:
//   swallow / forward / guest_key routing, prompt hand-off, the three chord
//   requests and the capture mode that holds after the event.
//   The event is captured in an input register, then the routing logic and
//   the chord state update write their outcome into the result register.
//   Throughput is one event per cycle while out_stall is low; the chord
//   state is updated in the same cycle that writes the result, so
//   back-to-back events see each other's effects.
//   When the receiver stalls, the result register holds and the input
//   register fills, after which in_stall rises; at most two events are in
//   flight. Reset clears the chord tracking state, capture mode and both
//   stages, and loads the default chord (Ctrl + Alt, two members).
//   Configuration goes through the APB-style port; write it only while idle.
`default_nettype none

module hotkey_chord_capture_router #(
    parameter int MAX_MEMBERS = hccr_pkg::MAX_MEMBERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,

    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [1:0]  action,
    input  wire logic [7:0]  key_code,
    input  wire logic        release_req,
    input  wire logic        has_focus,
    input  wire logic        prompt_armed,
    input  wire logic        screen_tab,

    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             swallow,
    output logic             forward,
    output logic      [7:0]  guest_key,
    output logic             to_prompt,
    output logic             req_three_finger,
    output logic             req_pause_flip,
    output logic             req_full_flip,
    output logic             capture_on
);

    // Members actually tracked: the parameter, capped by the four key registers.
    localparam int NUM_M = (MAX_MEMBERS < hccr_pkg::KEY_REGS) ? MAX_MEMBERS
                                                              : hccr_pkg::KEY_REGS;

    // ---------------------------------------------------------------- config
    logic [7:0] key_reg [hccr_pkg::KEY_REGS];
    logic [2:0] size_reg;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg[0] <= hccr_pkg::KEY_A_RST;
            key_reg[1] <= hccr_pkg::KEY_B_RST;
            key_reg[2] <= hccr_pkg::KEY_C_RST;
            key_reg[3] <= hccr_pkg::KEY_D_RST;
            size_reg   <= hccr_pkg::SIZE_RST;
        end
        else if (cfg_wr)
        begin
            // Decode on the word index; writes beyond the list are dropped.
            case (paddr[4:2])
                hccr_pkg::REG_KEY_A: key_reg[0] <= pwdata[7:0];
                hccr_pkg::REG_KEY_B: key_reg[1] <= pwdata[7:0];
                hccr_pkg::REG_KEY_C: key_reg[2] <= pwdata[7:0];
                hccr_pkg::REG_KEY_D: key_reg[3] <= pwdata[7:0];
                hccr_pkg::REG_SIZE:  size_reg   <= pwdata[2:0];
                default: ;
            endcase
        end
    end

    // Readback; unaligned addresses read as zero.
    always_comb
    begin
        prdata = '0;
        if (paddr[1:0] == 2'b00)
        begin
            case (paddr[4:2])
                hccr_pkg::REG_KEY_A: prdata = {24'd0, key_reg[0]};
                hccr_pkg::REG_KEY_B: prdata = {24'd0, key_reg[1]};
                hccr_pkg::REG_KEY_C: prdata = {24'd0, key_reg[2]};
                hccr_pkg::REG_KEY_D: prdata = {24'd0, key_reg[3]};
                hccr_pkg::REG_SIZE:  prdata = {29'd0, size_reg};
                default:             prdata = '0;
            endcase
        end
    end

    // ----------------------------------------------------------- input stage
    logic       s1_valid_reg, s1_valid_next;
    logic [1:0] s1_action_reg;
    logic [7:0] s1_code_reg;
    logic       s1_up_reg;
    logic       s1_focus_reg;
    logic       s1_prompt_reg;
    logic       s1_screen_reg;
    logic       in_take;
    logic       advance;

    // The result register can take a new value when empty or being drained.
    assign advance  = !out_valid || !out_stall;
    assign in_stall = s1_valid_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
            s1_valid_next = 1'b1;
        else if (advance)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_action_reg <= action;
            s1_code_reg   <= key_code;
            s1_up_reg     <= release_req;
            s1_focus_reg  <= has_focus;
            s1_prompt_reg <= prompt_armed;
            s1_screen_reg <= screen_tab;
        end
    end

    // ------------------------------------------------------- chord tracking
    logic [NUM_M-1:0] down_reg, down_next;
    logic [NUM_M-1:0] hidden_reg, hidden_next;
    logic             held_reg, held_next;
    logic             used_reg, used_next;
    logic             capture_reg, capture_next;

    logic [2:0]       n_use;
    logic [NUM_M-1:0] full_mask;
    logic [NUM_M-1:0] hit;
    logic             is_member;

    logic       swallow_c, forward_c, to_prompt_c;
    logic       cad_c, pause_c, full_c;
    logic [7:0] guest_c;

    // Clamp the chord size to 1..NUM_M.
    always_comb
    begin
        if (size_reg == 3'd0)
            n_use = 3'd1;
        else if (size_reg > 3'(NUM_M))
            n_use = 3'(NUM_M);
        else
            n_use = size_reg;
    end

    // All-down mask and the lowest matching member as a one-hot.
    always_comb
    begin
        full_mask = '0;
        hit       = '0;
        is_member = 1'b0;
        for (int i = 0; i < NUM_M; i++)
        begin
            full_mask[i] = (3'(i) < n_use);
            if (!is_member && (3'(i) < n_use) && (key_reg[i] == s1_code_reg))
            begin
                hit[i]    = 1'b1;
                is_member = 1'b1;
            end
        end
    end

    always_comb
    begin
        down_next    = down_reg;
        hidden_next  = hidden_reg;
        held_next    = held_reg;
        used_next    = used_reg;
        capture_next = capture_reg;
        swallow_c    = 1'b0;
        forward_c    = 1'b0;
        to_prompt_c  = 1'b0;
        cad_c        = 1'b0;
        pause_c      = 1'b0;
        full_c       = 1'b0;
        guest_c      = 8'd0;

        case (s1_action_reg)
            hccr_pkg::ACT_FOCUS_LOST:
            begin
                down_next    = '0;
                hidden_next  = '0;
                held_next    = 1'b0;
                used_next    = 1'b0;
                capture_next = 1'b0;
            end
            hccr_pkg::ACT_TOGGLE:
            begin
                capture_next = !capture_reg;
            end
            hccr_pkg::ACT_KEY:
            begin
                if (!s1_focus_reg)
                begin
                    // Background window: drop the event.
                end
                else if (!s1_up_reg && s1_prompt_reg)
                begin
                    to_prompt_c = 1'b1;
                    swallow_c   = 1'b1;
                end
                else if (is_member)
                begin
                    if (!s1_up_reg)
                    begin
                        if ((down_reg & hit) != '0)
                        begin
                            // Auto-repeat: hide it the same way as the first press.
                            swallow_c = (hidden_reg & hit) != '0;
                        end
                        else
                        begin
                            swallow_c = capture_reg;
                            down_next = down_reg | hit;
                            if (capture_reg)
                                hidden_next = hidden_reg | hit;
                            else
                                hidden_next = hidden_reg & ~hit;
                        end
                        if (!held_reg && (down_next == full_mask))
                        begin
                            held_next = 1'b1;
                            used_next = 1'b0;
                        end
                    end
                    else
                    begin
                        swallow_c   = (hidden_reg & hit) != '0;
                        down_next   = down_reg & ~hit;
                        hidden_next = hidden_reg & ~hit;
                        held_next   = 1'b0;
                        // Release of an unused chord flips capture.
                        if (held_reg && !used_reg)
                            capture_next = !capture_reg;
                    end
                end
                else
                begin
                    if (held_reg && !s1_up_reg)
                        used_next = 1'b1;
                    if (held_reg && (s1_code_reg == hccr_pkg::KEY_DELETE))
                    begin
                        swallow_c = 1'b1;
                        cad_c     = !s1_up_reg;
                    end
                    else if (held_reg && (s1_code_reg == hccr_pkg::KEY_P))
                    begin
                        swallow_c = 1'b1;
                        pause_c   = !s1_up_reg;
                    end
                    else if (held_reg && (s1_code_reg == hccr_pkg::KEY_F))
                    begin
                        swallow_c = 1'b1;
                        full_c    = !s1_up_reg;
                    end
                    else if (capture_reg)
                    begin
                        swallow_c = 1'b1;
                        if (s1_screen_reg)
                        begin
                            forward_c = 1'b1;
                            guest_c   = hccr_pkg::merge_sides(s1_code_reg);
                        end
                    end
                end
            end
            default:
            begin
                // Unused action code: no change.
            end
        endcase
    end

    // Commit the state only when the event moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            down_reg    <= '0;
            hidden_reg  <= '0;
            held_reg    <= 1'b0;
            used_reg    <= 1'b0;
            capture_reg <= 1'b0;
        end
        else if (advance && s1_valid_reg)
        begin
            down_reg    <= down_next;
            hidden_reg  <= hidden_next;
            held_reg    <= held_next;
            used_reg    <= used_next;
            capture_reg <= capture_next;
        end
    end

    // ---------------------------------------------------------- result stage
    logic       out_valid_reg, out_valid_next;
    logic       swallow_reg;
    logic       forward_reg;
    logic [7:0] guest_reg;
    logic       to_prompt_reg;
    logic       cad_reg;
    logic       pause_reg;
    logic       full_reg;
    logic       capture_on_reg;

    assign out_valid_next = advance ? s1_valid_reg : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            swallow_reg    <= swallow_c;
            forward_reg    <= forward_c;
            guest_reg      <= guest_c;
            to_prompt_reg  <= to_prompt_c;
            cad_reg        <= cad_c;
            pause_reg      <= pause_c;
            full_reg       <= full_c;
            capture_on_reg <= capture_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign swallow          = swallow_reg;
    assign forward          = forward_reg;
    assign guest_key        = guest_reg;
    assign to_prompt        = to_prompt_reg;
    assign req_three_finger = cad_reg;
    assign req_pause_flip   = pause_reg;
    assign req_full_flip    = full_reg;
    assign capture_on       = capture_on_reg;

`ifndef SYNTHESIS
    // A hidden press is always a press that is still down.
    assert property (@(posedge clk) disable iff (!rst_n)
        (hidden_reg & ~down_reg) == '0)
        else $error("hidden member key not marked down");

    // Anything sent to the guest is hidden from the host.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && forward_reg |-> swallow_reg)
        else $error("forwarded key not swallowed");

    // One chord request per event at most, and never with a prompt hand-off.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> $onehot0({cad_reg, pause_reg, full_reg, to_prompt_reg, forward_reg}))
        else $error("conflicting routing outcomes");

    // Input back-pressure only while the input register is occupied.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg)
        else $error("input stalled with room available");

    // Reported capture mode matches the tracked mode after the committed event.
    assert property (@(posedge clk) disable iff (!rst_n)
        advance && s1_valid_reg |=> capture_on_reg == capture_reg)
        else $error("capture_on out of step with capture state");
`endif

endmodule

`default_nettype wire
